// ===== sv/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg
// Types and constants shared by the touch event translator.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int Pads     = 2;
  localparam int PadIdxW  = (Pads > 1) ? $clog2(Pads) : 1;
  localparam int MaxRec   = 3;
  localparam int BackBit  = 3;

  localparam logic signed [17:0] ScrollMax  = 18'sd65536;
  localparam logic signed [17:0] ScrollMin  = -18'sd65536;
  localparam logic        [16:0] StepBias   = 17'd16383;

  typedef enum logic [1:0] {
    ReqTouch  = 2'd0,
    ReqButton = 2'd1,
    ReqScroll = 2'd2,
    ReqBad    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KindPos    = 3'd0,
    KindTouch  = 3'd1,
    KindBack   = 3'd2,
    KindLift   = 3'd3,
    KindHwheel = 3'd4,
    KindWheel  = 3'd5,
    KindSync   = 3'd6,
    KindNone   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInvalid  = 2'd1,
    StUnsup    = 2'd2,
    StDetached = 2'd3
  } status_e;

  // per-pad state entry
  typedef struct packed {
    logic [1:0]  hist;
    logic [15:0] x;
    logic [15:0] y;
    logic        known;
    logic [7:0]  btn;
  } entry_t;

  // one output word
  typedef struct packed {
    kind_e              kind;
    logic signed [3:0]  value;
    logic        [15:0] x;
    logic        [15:0] y;
    status_e            status;
    logic               last;
  } rec_t;

  localparam rec_t RecNone = '{kind: KindNone, value: 4'sd0, x: 16'd0, y: 16'd0,
                               status: StOk, last: 1'b0};

endpackage

// ===== sv/touch_event_translator.sv =====
// ----------------------------------------------------------------------------
// touch_event_translator
// Turns touch, button and scroll requests for virtual touchpads into
// multi-touch event words.
// ----------------------------------------------------------------------------
// The pad state of a request is read from the state RAM on the edge that
// accepts it. The registered request is then decoded; once the output buffer
// is free any state update is written back and its one to three event words
// are loaded there, sending one word per cycle on the single-word output port
// while out_stall_i is low; requests yielding one word each then run at one
// per cycle. The first word is presented once the request is in the output
// buffer. Writes to the pad just read are forwarded, so back-to-back requests
// to the same pad see the latest state. The last word of each request carries
// the status. After reset all pads read as zero.
module touch_event_translator (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         pad_i,
  input  logic signed [17:0] coord_x_i,
  input  logic signed [17:0] coord_y_i,
  input  logic signed [15:0] pressure_i,
  input  logic [7:0]         buttons_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         ev_kind_o,
  output logic signed [3:0]  ev_value_o,
  output logic [15:0]        pos_x_o,
  output logic [15:0]        pos_y_o,
  output logic [3:0]         out_pad_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int IdxW = tet_pkg::PadIdxW;

  logic                    attached_q;

  logic                    s1_valid_q;
  logic [1:0]              type_q;
  logic [3:0]              pad_q;
  logic signed [17:0]      x_q;
  logic signed [17:0]      y_q;
  logic signed [15:0]      pr_q;
  logic [7:0]              btn_q;

  tet_pkg::entry_t         mem_q [tet_pkg::Pads];
  logic [tet_pkg::Pads-1:0] vld_q;
  tet_pkg::entry_t         rd_q;
  logic                    rd_vld_q;

  tet_pkg::rec_t [tet_pkg::MaxRec-1:0] rec_q;
  logic [1:0]              rem_q;
  logic [3:0]              out_pad_q;

  logic                    accept;
  logic                    pop;
  logic                    buf_free;
  logic                    commit;
  logic                    we;
  logic                    we_eff;
  logic [IdxW-1:0]         wr_idx;
  logic [IdxW-1:0]         rd_idx;
  logic                    fwd_hit;
  tet_pkg::entry_t         st;
  tet_pkg::entry_t         wdata;
  tet_pkg::rec_t [tet_pkg::MaxRec-1:0] rec_d;
  logic [1:0]              n_d;

  assign pop        = out_valid_o && !out_stall_i;
  assign buf_free   = (rem_q == 2'd0) || ((rem_q == 2'd1) && !out_stall_i);
  assign commit     = s1_valid_q && buf_free;
  assign in_stall_o = s1_valid_q && !buf_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_idx  = pad_q[IdxW-1:0];
  assign rd_idx  = pad_i[IdxW-1:0];
  assign we_eff  = commit && we;
  assign fwd_hit = we_eff && (wr_idx == rd_idx);
  assign st      = rd_vld_q ? rd_q : '0;

  // decode and event generation
  always_comb begin
    logic              inv_req;
    logic [1:0]        h;
    logic              moved;
    logic [7:0]        chg;
    logic [17:0]       ax;
    logic [17:0]       ay;
    logic [16:0]       sumx;
    logic [16:0]       sumy;
    logic [2:0]        sx;
    logic [2:0]        sy;
    logic signed [3:0] vx;
    logic signed [3:0] vy;
    tet_pkg::status_e  stat;

    rec_d   = {tet_pkg::MaxRec{tet_pkg::RecNone}};
    n_d     = 2'd0;
    stat    = tet_pkg::StOk;
    we      = 1'b0;
    wdata   = st;
    inv_req = ({1'b0, pad_q} >= 5'(tet_pkg::Pads)) || (type_q == tet_pkg::ReqBad);
    h       = {st.hist[0], !pr_q[15] && (pr_q != 16'sd0)};
    moved   = !st.known || (st.x != x_q[15:0]) || (st.y != y_q[15:0]);
    chg     = st.btn ^ btn_q;
    ax      = x_q[17] ? 18'(-x_q) : 18'(x_q);
    ay      = y_q[17] ? 18'(-y_q) : 18'(y_q);
    sumx    = ax[16:0] + tet_pkg::StepBias;
    sumy    = ay[16:0] + tet_pkg::StepBias;
    sx      = sumx[16:14];
    sy      = sumy[16:14];
    vx      = x_q[17] ? -$signed({1'b0, sx}) : $signed({1'b0, sx});
    vy      = y_q[17] ? -$signed({1'b0, sy}) : $signed({1'b0, sy});

    if (inv_req) begin
      stat = tet_pkg::StInvalid;
    end else begin
      case (type_q)
        tet_pkg::ReqTouch: begin
          if ((x_q[17:16] != 2'b00) || (y_q[17:16] != 2'b00)) begin
            stat = tet_pkg::StInvalid;
          end else begin
            we         = 1'b1;
            wdata.hist = h;
            if (!attached_q) begin
              stat = tet_pkg::StDetached;
            end else begin
              wdata.x     = x_q[15:0];
              wdata.y     = y_q[15:0];
              wdata.known = 1'b1;
              if (h == 2'b01) begin
                rec_d[0].kind  = tet_pkg::KindPos;
                rec_d[0].x     = x_q[15:0];
                rec_d[0].y     = y_q[15:0];
                rec_d[1].kind  = tet_pkg::KindTouch;
                rec_d[1].value = 4'sd1;
                rec_d[2].kind  = tet_pkg::KindSync;
                n_d            = 2'd3;
              end else if (h == 2'b10) begin
                rec_d[0].kind = tet_pkg::KindTouch;
                rec_d[1].kind = tet_pkg::KindLift;
                rec_d[2].kind = tet_pkg::KindSync;
                n_d           = 2'd3;
              end else if (moved) begin
                rec_d[0].kind = tet_pkg::KindPos;
                rec_d[0].x    = x_q[15:0];
                rec_d[0].y    = y_q[15:0];
                rec_d[1].kind = tet_pkg::KindSync;
                n_d           = 2'd2;
              end
            end
          end
        end
        tet_pkg::ReqButton: begin
          if (chg == 8'd0) begin
            stat = tet_pkg::StOk;
          end else if ((btn_q & ~(8'd1 << tet_pkg::BackBit)) != 8'd0) begin
            stat = tet_pkg::StUnsup;
          end else if (!attached_q) begin
            stat = tet_pkg::StDetached;
          end else begin
            we        = 1'b1;
            wdata.btn = btn_q;
            if (chg[tet_pkg::BackBit]) begin
              rec_d[0].kind  = tet_pkg::KindBack;
              rec_d[0].value = btn_q[tet_pkg::BackBit] ? 4'sd1 : 4'sd0;
              rec_d[1].kind  = tet_pkg::KindSync;
              n_d            = 2'd2;
            end
          end
        end
        tet_pkg::ReqScroll: begin
          if ((x_q < tet_pkg::ScrollMin) || (x_q > tet_pkg::ScrollMax) ||
              (y_q < tet_pkg::ScrollMin) || (y_q > tet_pkg::ScrollMax)) begin
            stat = tet_pkg::StInvalid;
          end else if (!attached_q) begin
            stat = tet_pkg::StDetached;
          end else if ((sx != 3'd0) && (sy != 3'd0)) begin
            rec_d[0].kind  = tet_pkg::KindHwheel;
            rec_d[0].value = vx;
            rec_d[1].kind  = tet_pkg::KindWheel;
            rec_d[1].value = vy;
            rec_d[2].kind  = tet_pkg::KindSync;
            n_d            = 2'd3;
          end else if (sx != 3'd0) begin
            rec_d[0].kind  = tet_pkg::KindHwheel;
            rec_d[0].value = vx;
            rec_d[1].kind  = tet_pkg::KindSync;
            n_d            = 2'd2;
          end else if (sy != 3'd0) begin
            rec_d[0].kind  = tet_pkg::KindWheel;
            rec_d[0].value = vy;
            rec_d[1].kind  = tet_pkg::KindSync;
            n_d            = 2'd2;
          end
        end
        default: begin
          stat = tet_pkg::StInvalid;
        end
      endcase
    end

    if (n_d == 2'd0) begin
      n_d = 2'd1;
    end
    for (int i = 0; i < tet_pkg::MaxRec; i++) begin
      if (2'(i) == (n_d - 2'd1)) begin
        rec_d[i].status = stat;
        rec_d[i].last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= 1'b0;
    end else if (cfg_we_i) begin
      attached_q <= cfg_wdata_i;
    end
  end

  // request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (commit) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= req_type_i;
      pad_q  <= pad_i;
      x_q    <= coord_x_i;
      y_q    <= coord_y_i;
      pr_q   <= pressure_i;
      btn_q  <= buttons_i;
    end
  end

  // state RAM, read with forwarding of the write on the same edge
  always_ff @(posedge clk_i) begin
    if (we_eff) begin
      mem_q[wr_idx] <= wdata;
    end
    if (accept) begin
      rd_q <= fwd_hit ? wdata : mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_eff) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (accept) begin
        rd_vld_q <= fwd_hit || vld_q[rd_idx];
      end
    end
  end

  // output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (commit) begin
      rem_q <= n_d;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rec_q     <= rec_d;
      out_pad_q <= pad_q;
    end else if (pop) begin
      rec_q[0] <= rec_q[1];
      rec_q[1] <= rec_q[2];
    end
  end

  assign out_valid_o = (rem_q != 2'd0);
  assign ev_kind_o   = rec_q[0].kind;
  assign ev_value_o  = rec_q[0].value;
  assign pos_x_o     = rec_q[0].x;
  assign pos_y_o     = rec_q[0].y;
  assign out_pad_o   = out_pad_q;
  assign status_o    = rec_q[0].status;
  assign last_o      = rec_q[0].last;

`ifndef ASSERT_OFF
  a_more_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("word stream of a request broken before last");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == tet_pkg::StOk)
    else $error("status on a non-final word");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_eff |-> ({1'b0, pad_q} < 5'(tet_pkg::Pads)))
    else $error("state write for an invalid pad");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o)
    else $error("input stalled with no pending work");
`endif

endmodule
